FILE: design/mce_pkg.sv
`default_nettype none
package mce_pkg;

  // sample and mix arithmetic
  localparam int SAMPLE_W = 24;
  localparam int MIX_FRAC = 8;
  localparam logic [MIX_FRAC:0] MIX_ONE = (MIX_FRAC+1)'(1) << MIX_FRAC;
  localparam logic [MIX_FRAC:0] MIX_HALF = MIX_ONE >> 1;

  // column length, unsigned Q16.8
  localparam int LEN_FRAC = 8;
  localparam int LEN_W = 24;
  localparam int CNT_W = LEN_W - LEN_FRAC + 1;
  localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(1) << LEN_FRAC;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(6144);
  localparam logic [CNT_W-1:0] CNT_RESET = CNT_W'(LEN_RESET >> LEN_FRAC);
  localparam logic [LEN_FRAC-1:0] FRAC_RESET = LEN_RESET[LEN_FRAC-1:0];

  // configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_LENGTH = 2'd2;

  // channel matrix modes
  localparam int MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_LEFT_RIGHT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_MID_SIDE = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MID = 3'd4;
  localparam logic [MODE_W-1:0] MODE_SIDE = 3'd5;

  // colors
  localparam int COLOR_W = 24;
  localparam logic [COLOR_W-1:0] STATIC_COLOR_A = 24'hff3366;
  localparam logic [COLOR_W-1:0] STATIC_COLOR_B = 24'h3399ff;
  localparam logic [COLOR_W-1:0] HEAT_STOP_LOW = 24'h00ccff;
  localparam logic [COLOR_W-1:0] HEAT_STOP_MID = 24'hccff00;
  localparam logic [COLOR_W-1:0] HEAT_STOP_HIGH = 24'hff0055;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // mixed track values of one sample
  typedef struct packed {
    sample_t va;
    sample_t vb;
  } mix_t;

  // extremes of one finished column
  typedef struct packed {
    sample_t min_a;
    sample_t max_a;
    sample_t min_b;
    sample_t max_b;
  } col_t;

endpackage
`default_nettype wire

FILE: design/mce_mix.sv
`default_nettype none
module mce_mix (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  input  wire mce_pkg::sample_t             in_left,
  input  wire mce_pkg::sample_t             in_right,
  input  wire logic [mce_pkg::MODE_W-1:0]   channel_mode,
  output logic                              up_ready,
  output logic                              mix_valid,
  output mce_pkg::mix_t                     mix_beat,
  input  wire logic                         down_ready
);
  import mce_pkg::*;

  logic                  valid_r;
  mix_t                  beat_r;
  mix_t                  beat_nxt;
  logic signed [SAMPLE_W:0] sum;
  logic signed [SAMPLE_W:0] diff;
  sample_t               mid;
  sample_t               side;

  // halved sum and difference, floored
  assign sum  = {in_left[SAMPLE_W-1], in_left} + {in_right[SAMPLE_W-1], in_right};
  assign diff = {in_left[SAMPLE_W-1], in_left} - {in_right[SAMPLE_W-1], in_right};
  assign mid  = sum[SAMPLE_W:1];
  assign side = diff[SAMPLE_W:1];

  // channel matrix
  always_comb begin
    beat_nxt = '0;
    unique case (channel_mode)
      MODE_LEFT_RIGHT: begin
        beat_nxt.va = in_left;
        beat_nxt.vb = in_right;
      end
      MODE_MID_SIDE: begin
        beat_nxt.va = mid;
        beat_nxt.vb = side;
      end
      MODE_LEFT:  beat_nxt.va = in_left;
      MODE_RIGHT: beat_nxt.va = in_right;
      MODE_MID:   beat_nxt.va = mid;
      MODE_SIDE:  beat_nxt.va = side;
      default:    beat_nxt = '0;
    endcase
  end

  assign up_ready  = !valid_r || down_ready;
  assign mix_valid = valid_r;
  assign mix_beat  = beat_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && in_valid) begin
      beat_r <= beat_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/mce_accum.sv
`default_nettype none
module mce_accum (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        mix_valid,
  input  wire mce_pkg::mix_t               mix_beat,
  input  wire logic [mce_pkg::LEN_W-1:0]   column_length,
  output logic                             up_ready,
  output logic                             col_valid,
  output mce_pkg::col_t                    col_beat,
  input  wire logic                        down_ready
);
  import mce_pkg::*;

  sample_t               run_min_a_r;
  sample_t               run_max_a_r;
  sample_t               run_min_b_r;
  sample_t               run_max_b_r;
  logic [CNT_W-1:0]      remaining_r;
  logic [LEN_FRAC-1:0]   frac_r;
  logic                  col_valid_r;
  col_t                  col_r;

  col_t                  ext_nxt;
  logic                  take;
  logic                  boundary;
  logic [LEN_W-1:0]      eff_len;
  logic [LEN_W:0]        next_end;

  assign up_ready  = !col_valid_r || down_ready;
  assign take      = mix_valid && up_ready;
  assign col_valid = col_valid_r;
  assign col_beat  = col_r;

  // running extremes including the current sample
  always_comb begin
    ext_nxt.min_a = (mix_beat.va < run_min_a_r) ? mix_beat.va : run_min_a_r;
    ext_nxt.max_a = (mix_beat.va > run_max_a_r) ? mix_beat.va : run_max_a_r;
    ext_nxt.min_b = (mix_beat.vb < run_min_b_r) ? mix_beat.vb : run_min_b_r;
    ext_nxt.max_b = (mix_beat.vb > run_max_b_r) ? mix_beat.vb : run_max_b_r;
  end

  // last sample of a column, and the end of the next one
  assign boundary = (remaining_r[CNT_W-1:1] == '0);
  assign eff_len  = (column_length[LEN_W-1:LEN_FRAC] == '0) ? LEN_MIN : column_length;
  assign next_end = {1'b0, {(LEN_W-LEN_FRAC){1'b0}}, frac_r} + {1'b0, eff_len};

  // running state and column counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_min_a_r <= '0;
      run_max_a_r <= '0;
      run_min_b_r <= '0;
      run_max_b_r <= '0;
      remaining_r <= CNT_RESET;
      frac_r      <= FRAC_RESET;
    end else if (take) begin
      if (boundary) begin
        run_min_a_r <= '0;
        run_max_a_r <= '0;
        run_min_b_r <= '0;
        run_max_b_r <= '0;
        remaining_r <= next_end[LEN_W:LEN_FRAC];
        frac_r      <= next_end[LEN_FRAC-1:0];
      end else begin
        run_min_a_r <= ext_nxt.min_a;
        run_max_a_r <= ext_nxt.max_a;
        run_min_b_r <= ext_nxt.min_b;
        run_max_b_r <= ext_nxt.max_b;
        remaining_r <= remaining_r - CNT_W'(1);
      end
    end
  end

  // finished column register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_valid_r <= 1'b0;
    end else if (up_ready) begin
      col_valid_r <= take && boundary;
    end
  end

  always_ff @(posedge clk) begin
    if (take && boundary) begin
      col_r <= ext_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: design/mce_color.sv
`default_nettype none
module mce_color (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          col_valid,
  input  wire mce_pkg::col_t                 col_beat,
  input  wire logic                          color_mode,
  output logic                               up_ready,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output mce_pkg::col_t                      out_col,
  output logic [mce_pkg::COLOR_W-1:0]        out_color_a,
  output logic [mce_pkg::COLOR_W-1:0]        out_color_b
);
  import mce_pkg::*;

  // position on the heat map: segment and blend weight
  typedef struct packed {
    logic                seg;
    logic [MIX_FRAC:0]   t;
  } heat_t;

  typedef struct packed {
    col_t   col;
    heat_t  heat_a;
    heat_t  heat_b;
  } heat_beat_t;

  logic                  heat_valid_r;
  heat_beat_t            heat_r;
  heat_beat_t            heat_nxt;
  logic                  out_valid_r;
  col_t                  out_col_r;
  logic [COLOR_W-1:0]    color_a_r;
  logic [COLOR_W-1:0]    color_b_r;
  logic [COLOR_W-1:0]    color_a_nxt;
  logic [COLOR_W-1:0]    color_b_nxt;
  logic                  out_ready;

  // peak times 1.5, in mix fraction units, saturated at one
  function automatic heat_t heat_pos(input sample_t mn, input sample_t mx);
    logic [SAMPLE_W-1:0]          neg;
    logic [SAMPLE_W-1:0]          peak;
    logic [SAMPLE_W+1:0]          prod3;
    logic [SAMPLE_W+MIX_FRAC:0]   scaled;
    logic [MIX_FRAC:0]            a;
    logic [MIX_FRAC:0]            above;
    heat_t                        h;
    neg    = (~mn) + SAMPLE_W'(1);
    peak   = ($unsigned(mx) > neg) ? $unsigned(mx) : neg;
    prod3  = {2'b00, peak} + {1'b0, peak, 1'b0};
    scaled = {prod3, {(MIX_FRAC-1){1'b0}}};
    a      = scaled[SAMPLE_W-1 +: MIX_FRAC+1];
    if (a > MIX_ONE) begin
      a = MIX_ONE;
    end
    above = a - MIX_HALF;
    if (a < MIX_HALF) begin
      h.seg = 1'b0;
      h.t   = {a[MIX_FRAC-1:0], 1'b0};
    end else begin
      h.seg = 1'b1;
      h.t   = {above[MIX_FRAC-1:0], 1'b0};
    end
    return h;
  endfunction

  // linear blend per color channel
  function automatic logic [COLOR_W-1:0] blend(input logic [COLOR_W-1:0] c0,
                                               input logic [COLOR_W-1:0] c1,
                                               input logic [MIX_FRAC:0] t);
    logic [COLOR_W-1:0]       res;
    logic [MIX_FRAC:0]        w0;
    logic [MIX_FRAC+9:0]      acc;
    w0  = MIX_ONE - t;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = (MIX_FRAC+10)'(c0[ch*8 +: 8]) * (MIX_FRAC+10)'(w0)
          + (MIX_FRAC+10)'(c1[ch*8 +: 8]) * (MIX_FRAC+10)'(t);
      res[ch*8 +: 8] = acc[MIX_FRAC +: 8];
    end
    return res;
  endfunction

  function automatic logic [COLOR_W-1:0] heat_color(input heat_t h);
    logic [COLOR_W-1:0] c;
    if (h.seg) begin
      c = blend(HEAT_STOP_MID, HEAT_STOP_HIGH, h.t);
    end else begin
      c = blend(HEAT_STOP_LOW, HEAT_STOP_MID, h.t);
    end
    return c;
  endfunction

  assign out_ready = !out_valid_r || !out_stall;
  assign up_ready  = !heat_valid_r || out_ready;

  // heat map position stage
  always_comb begin
    heat_nxt.col    = col_beat;
    heat_nxt.heat_a = heat_pos(col_beat.min_a, col_beat.max_a);
    heat_nxt.heat_b = heat_pos(col_beat.min_b, col_beat.max_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heat_valid_r <= 1'b0;
    end else if (up_ready) begin
      heat_valid_r <= col_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && col_valid) begin
      heat_r <= heat_nxt;
    end
  end

  // color select
  always_comb begin
    if (color_mode) begin
      color_a_nxt = heat_color(heat_r.heat_a);
      color_b_nxt = heat_color(heat_r.heat_b);
    end else begin
      color_a_nxt = STATIC_COLOR_A;
      color_b_nxt = STATIC_COLOR_B;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready) begin
      out_valid_r <= heat_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && heat_valid_r) begin
      out_col_r <= heat_r.col;
      color_a_r <= color_a_nxt;
      color_b_r <= color_b_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_col     = out_col_r;
  assign out_color_a = color_a_r;
  assign out_color_b = color_b_r;

endmodule
`default_nettype wire

FILE: design/minmax_column_envelope_top.sv
// a column's result passes from the column register through the heat and result registers
// throughput: one sample beat per cycle unless stalled; four register stages (mix, column,
// heat, result) each hold one beat and advance whenever the stage after them is free
// reset: synchronous, active low; clears pipeline valid flags and running extremes,
// restores config defaults and loads the column counter from the reset column length
`default_nettype none
module minmax_column_envelope_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire mce_pkg::sample_t                in_left_sample,
  input  wire mce_pkg::sample_t                in_right_sample,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output mce_pkg::sample_t                     out_track_a_min,
  output mce_pkg::sample_t                     out_track_a_max,
  output mce_pkg::sample_t                     out_track_b_min,
  output mce_pkg::sample_t                     out_track_b_max,
  output logic [mce_pkg::COLOR_W-1:0]          out_track_a_color,
  output logic [mce_pkg::COLOR_W-1:0]          out_track_b_color,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mce_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mce_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mce_pkg::*;

  logic [MODE_W-1:0]   channel_mode_r;
  logic                color_mode_r;
  logic [LEN_W-1:0]    column_length_r;

  logic                mix_ready;
  logic                mix_valid;
  mix_t                mix_beat;
  logic                acc_ready;
  logic                col_valid;
  col_t                col_beat;
  logic                color_ready;
  col_t                out_col;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      channel_mode_r  <= MODE_LEFT_RIGHT;
      color_mode_r    <= 1'b0;
      column_length_r <= LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CHANNEL_MODE:  channel_mode_r  <= cfg_data[MODE_W-1:0];
        CFG_COLOR_MODE:    color_mode_r    <= cfg_data[0];
        CFG_COLUMN_LENGTH: column_length_r <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // channel matrix stage
  mce_mix u_mix (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_left      (in_left_sample),
    .in_right     (in_right_sample),
    .channel_mode (channel_mode_r),
    .up_ready     (mix_ready),
    .mix_valid    (mix_valid),
    .mix_beat     (mix_beat),
    .down_ready   (acc_ready)
  );

  assign in_stall = !mix_ready;

  // running extremes and column boundaries
  mce_accum u_accum (
    .clk           (clk),
    .rst_n         (rst_n),
    .mix_valid     (mix_valid),
    .mix_beat      (mix_beat),
    .column_length (column_length_r),
    .up_ready      (acc_ready),
    .col_valid     (col_valid),
    .col_beat      (col_beat),
    .down_ready    (color_ready)
  );

  // colors and result register
  mce_color u_color (
    .clk         (clk),
    .rst_n       (rst_n),
    .col_valid   (col_valid),
    .col_beat    (col_beat),
    .color_mode  (color_mode_r),
    .up_ready    (color_ready),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_col     (out_col),
    .out_color_a (out_track_a_color),
    .out_color_b (out_track_b_color)
  );

  assign out_track_a_min = out_col.min_a;
  assign out_track_a_max = out_col.max_a;
  assign out_track_b_min = out_col.min_b;
  assign out_track_b_max = out_col.max_b;

endmodule
`default_nettype wire
